>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/spq_pkg.sv
package spq_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STAT_PUSHED   = 2'd0;
    localparam logic [1:0] STAT_POPPED   = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] item_value;
        logic [7:0]         item_priority;
    } spq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic [7:0]         out_priority;
        logic [3:0]         fill_count;
    } spq_resp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_DATA,
        S_SCAN,
        S_PLACE
    } spq_state_t;

endpackage

>>> hdl/spq_ram.sv
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sorted_priority_queue_unit.sv
// Result register: loaded in S_EXEC for an overflow push or empty pop, in S_POP_DATA
// for a pop after the RAM read, in S_PLACE for a push after S_SCAN (none if empty),
// which walks from the tail, moving each entry with a larger priority number one slot.
// One request in flight; the next is accepted the cycle after the result is registered,
// and a finished result waits in its last state while the output register is still full.
// aresetn (sync, active low) clears count, head, FSM, output valid; RAM is not reset.
`include "assert_macros.svh"

module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH      = 8,
    parameter int PRIO_WIDTH = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  spq_req_t  s_req,
    output logic      m_valid,
    input  logic      m_ready,
    output spq_resp_t m_resp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = 32 + PRIO_WIDTH;

    // Control state
    spq_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg,  head_next;   // physical slot of the front entry
    logic [AW-1:0] k_reg,     k_next;      // logical index being read in the scan
    logic [AW-1:0] place_reg, place_next;  // logical slot for the new entry
    spq_req_t      req_reg,   req_next;
    logic          m_valid_reg, m_valid_next;
    spq_resp_t     resp_reg,  resp_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    logic [PRIO_WIDTH-1:0] push_prio;
    logic [PRIO_WIDTH-1:0] rd_prio;
    logic signed [31:0]    rd_value;
    logic                  out_free;
    logic                  q_empty;
    logic                  q_full;
    logic                  is_pop;
    logic                  scan_move;

    // Logical index -> physical slot in the circular buffer.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    spq_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign push_prio = PRIO_WIDTH'(req_reg.item_priority);
    assign rd_prio   = ram_rdata[PRIO_WIDTH-1:0];
    assign rd_value  = ram_rdata[WW-1:PRIO_WIDTH];
    assign out_free  = !m_valid_reg || m_ready;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CW'(DEPTH));
    assign is_pop    = (req_reg.cmd == CMD_POP);
    // Stored entry leaves after the new one: it moves one slot toward the tail.
    assign scan_move = (rd_prio > push_prio);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_resp  = resp_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (is_pop) begin
                    if (!q_empty) begin
                        state_next = S_POP_DATA;
                    end else if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    if (q_full) begin
                        if (out_free) begin
                            state_next = S_IDLE;
                        end
                    end else if (q_empty) begin
                        state_next = S_PLACE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_POP_DATA: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!scan_move || k_reg == '0) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM port and result register
    always_comb begin
        count_next   = count_reg;
        head_next    = head_reg;
        k_next       = k_reg;
        place_next   = place_reg;
        req_next     = req_reg;
        resp_next    = resp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_req;
                end
            end
            S_EXEC: begin
                if (is_pop) begin
                    if (!q_empty) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_reg;
                    end else if (out_free) begin
                        m_valid_next           = 1'b1;
                        resp_next.status       = STAT_EMPTY;
                        resp_next.out_value    = '0;
                        resp_next.out_priority = '0;
                        resp_next.fill_count   = 4'(count_reg);
                    end
                end else begin
                    if (q_full) begin
                        if (out_free) begin
                            m_valid_next           = 1'b1;
                            resp_next.status       = STAT_OVERFLOW;
                            resp_next.out_value    = '0;
                            resp_next.out_priority = '0;
                            resp_next.fill_count   = 4'(count_reg);
                        end
                    end else if (q_empty) begin
                        place_next = '0;
                    end else begin
                        // walk from the tail toward the front
                        k_next    = AW'(count_reg - 1'b1);
                        ram_re    = 1'b1;
                        ram_raddr = phys(head_reg, AW'(count_reg - 1'b1));
                    end
                end
            end
            S_POP_DATA: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    resp_next.status       = STAT_POPPED;
                    resp_next.out_value    = rd_value;
                    resp_next.out_priority = 8'(rd_prio);
                    resp_next.fill_count   = 4'(count_reg - 1'b1);
                    count_next             = count_reg - 1'b1;
                    head_next              = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                          : head_reg + 1'b1;
                end
            end
            S_SCAN: begin
                // write k+1 while reading k-1: never the same slot, no interlock
                if (scan_move) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(head_reg, k_reg + 1'b1);
                    ram_wdata = ram_rdata;
                    if (k_reg == '0) begin
                        place_next = '0;
                    end else begin
                        k_next    = k_reg - 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = phys(head_reg, k_reg - 1'b1);
                    end
                end else begin
                    place_next = k_reg + 1'b1;
                end
            end
            S_PLACE: begin
                if (out_free) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = phys(head_reg, place_reg);
                    ram_wdata              = {req_reg.item_value, push_prio};
                    count_next             = count_reg + 1'b1;
                    m_valid_next           = 1'b1;
                    resp_next.status       = STAT_PUSHED;
                    resp_next.out_value    = '0;
                    resp_next.out_priority = '0;
                    resp_next.fill_count   = 4'(count_reg + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        place_reg <= place_next;
        req_reg   <= req_next;
        resp_reg  <= resp_next;
    end

    // Checks
    `ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_IMPLY(a_no_rw_collide, aclk, aresetn, ram_we && ram_re, ram_waddr != ram_raddr)
    `ASSERT_NEXT(a_pop_dec, aclk, aresetn, state_reg == S_POP_DATA && out_free, count_reg == CW'($past(count_reg) - 1'b1))
    `ASSERT_IMPLY(a_one_in_flight, aclk, aresetn, state_reg != S_IDLE, !s_ready)

endmodule

>>> verif/tb.sv
module tb;
    import spq_pkg::*;

    localparam int QDEPTH           = 8;
    localparam int RANDOM_PER_PHASE = 383;  // four phases plus the directed table, ~1550
    localparam int IDLE_LIMIT       = 2000; // cycles without any handshake
    localparam int SETTLE_CYCLES    = 30;   // quiet time before the summary

    typedef struct {
        spq_req_t  req;
        bit        typed;   // want holds a hand-written result
        spq_resp_t want;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    spq_req_t  s_req   = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    spq_resp_t m_resp;

    sorted_priority_queue_unit #(
        .DEPTH     (QDEPTH),
        .PRIO_WIDTH(8)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_resp (m_resp)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the queue contents, kept sorted like the block's array.
    logic signed [31:0] held_val [QDEPTH];
    logic [7:0]         held_pri [QDEPTH];
    int                 held_cnt = 0;

    spq_resp_t expected_q [$];
    stim_row_t directed_rows [$];
    int        status_seen [4];
    int        requests_sent = 0;
    int        mismatches    = 0;
    int        quiet_cycles  = 0;
    int        tx_idle_pct   = 0;
    int        rx_stall_pct  = 0;

    // Applies one request to the shadow queue and returns the result it must produce.
    // Pushes go after every entry with an equal or smaller priority number, so
    // ties leave in arrival order.
    function automatic spq_resp_t queue_apply(input spq_req_t r);
        spq_resp_t res;
        int        pos;
        res = '0;
        if (r.cmd == CMD_PUSH) begin
            if (held_cnt >= QDEPTH) begin
                res.status = STAT_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < held_cnt && held_pri[pos] <= r.item_priority) pos++;
                for (int k = held_cnt; k > pos; k--) begin
                    held_val[k] = held_val[k-1];
                    held_pri[k] = held_pri[k-1];
                end
                held_val[pos] = r.item_value;
                held_pri[pos] = r.item_priority;
                held_cnt++;
                res.status = STAT_PUSHED;
            end
        end else if (held_cnt == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            res.status       = STAT_POPPED;
            res.out_value    = held_val[0];
            res.out_priority = held_pri[0];
            for (int k = 0; k + 1 < held_cnt; k++) begin
                held_val[k] = held_val[k+1];
                held_pri[k] = held_pri[k+1];
            end
            held_cnt--;
        end
        res.fill_count = 4'(held_cnt);
        return res;
    endfunction

    function automatic void add_row(input logic cmd, input logic [31:0] val,
                                    input logic [7:0] pri, input bit typed,
                                    input logic [1:0] st, input logic [31:0] oval,
                                    input logic [7:0] opri, input logic [3:0] fill);
        stim_row_t row;
        row.req.cmd           = cmd;
        row.req.item_value    = val;
        row.req.item_priority = pri;
        row.typed             = typed;
        row.want.status       = st;
        row.want.out_value    = oval;
        row.want.out_priority = opri;
        row.want.fill_count   = fill;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Presents one request, holds it until accepted, then records what must come back.
    // Afterwards the sender may sit idle for a random number of cycles.
    task automatic send_request(input spq_req_t r, input bit typed, input spq_resp_t want);
        spq_resp_t predicted;
        s_req   <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = queue_apply(r);
        status_seen[predicted.status]++;
        expected_q.push_back(typed ? want : predicted);
        requests_sent++;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Result side: random backpressure at the rate of the current phase.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_stall_pct);

    // Every accepted result is matched against the oldest outstanding expectation.
    always @(posedge aclk) begin
        spq_resp_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: %h", m_resp));
            end else begin
                want = expected_q.pop_front();
                if (m_resp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_resp.status, want.status));
                if (m_resp.out_value !== want.out_value)
                    report_mismatch($sformatf("out_value got %h want %h",
                                              m_resp.out_value, want.out_value));
                if (m_resp.out_priority !== want.out_priority)
                    report_mismatch($sformatf("out_priority got %0d want %0d",
                                              m_resp.out_priority, want.out_priority));
                if (m_resp.fill_count !== want.fill_count)
                    report_mismatch($sformatf("fill_count got %0d want %0d",
                                              m_resp.fill_count, want.fill_count));
            end
        end
    end

    // Hang detector: no request and no result moving for too long ends the run.
    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_q.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        spq_req_t  r;
        spq_resp_t no_want;
        int        push_pct;

        no_want  = '0;
        push_pct = 50;

        // Directed table. Hand-written results where they are obvious; pops of a
        // filled queue go through the shadow queue.
        add_row(CMD_POP,  32'h7FFF_FFFF, 8'hFF, 1'b1, STAT_EMPTY,    '0, '0, 4'd0); // pop on empty
        add_row(CMD_PUSH, 32'h7FFF_FFFF, 8'hFF, 1'b1, STAT_PUSHED,   '0, '0, 4'd1); // max value/prio
        add_row(CMD_PUSH, 32'h8000_0000, 8'h00, 1'b1, STAT_PUSHED,   '0, '0, 4'd2); // min value/prio
        add_row(CMD_PUSH, 32'h0000_0001, 8'd100, 1'b1, STAT_PUSHED,  '0, '0, 4'd3);
        add_row(CMD_PUSH, 32'h0000_0002, 8'd100, 1'b1, STAT_PUSHED,  '0, '0, 4'd4); // tie, mid
        add_row(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 1'b1, STAT_PUSHED,   '0, '0, 4'd5); // tie, last
        add_row(CMD_PUSH, 32'h0000_0000, 8'h00, 1'b1, STAT_PUSHED,   '0, '0, 4'd6); // zero, tie
        add_row(CMD_PUSH, 32'h5555_5555, 8'hAA, 1'b1, STAT_PUSHED,   '0, '0, 4'd7);
        add_row(CMD_PUSH, 32'hAAAA_AAAA, 8'h55, 1'b1, STAT_PUSHED,   '0, '0, 4'd8); // now full
        add_row(CMD_PUSH, 32'h0000_0003, 8'h01, 1'b1, STAT_OVERFLOW, '0, '0, 4'd8); // dropped
        add_row(CMD_PUSH, 32'h0000_0004, 8'h00, 1'b1, STAT_OVERFLOW, '0, '0, 4'd8); // dropped
        for (int i = 0; i < QDEPTH; i++)
            add_row(CMD_POP, (i % 2) ? 32'hFFFF_FFFF : 32'h0, (i % 2) ? 8'hFF : 8'h0,
                    1'b0, STAT_POPPED, '0, '0, 4'd0);
        add_row(CMD_POP,  32'h0000_0000, 8'h00, 1'b1, STAT_EMPTY,    '0, '0, 4'd0); // drained
        add_row(CMD_PUSH, 32'h0000_0009, 8'h07, 1'b1, STAT_PUSHED,   '0, '0, 4'd1);
        add_row(CMD_POP,  32'h1234_5678, 8'h3C, 1'b0, STAT_POPPED,   '0, '0, 4'd0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random part: four idle/stall mixes; the push share shifts every 32 requests
        // so the queue swings between empty, partly filled and full.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(4))
                        0: push_pct = 10;
                        1: push_pct = 35;
                        2: push_pct = 50;
                        3: push_pct = 65;
                        default: push_pct = 90;
                    endcase
                end
                r.cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: r.item_priority = 8'($urandom_range(3)); // many ties
                    5: r.item_priority = 8'h00;
                    6: r.item_priority = 8'hFF;
                    default: r.item_priority = 8'($urandom_range(255));
                endcase
                case ($urandom_range(15))
                    0: r.item_value = 32'h8000_0000;
                    1: r.item_value = 32'h7FFF_FFFF;
                    default: r.item_value = $urandom;
                endcase
                send_request(r, 1'b0, no_want);
            end
            // Hold off new requests until every outstanding result has come back.
            s_valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge aclk);
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d requests; pushed %0d, popped %0d, overflow %0d, empty pop %0d",
                 requests_sent, status_seen[STAT_PUSHED], status_seen[STAT_POPPED],
                 status_seen[STAT_OVERFLOW], status_seen[STAT_EMPTY]);
        $display("summary: free-running, sender gaps, result stalls and both; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
